[hw/rtl/cpm_pkg.sv]
// Shared constants, types and a helper function for the complex sample to pixel mapper.
package cpm_pkg;

  localparam int InW       = 40;
  localparam int ColW      = 8;
  localparam int ModeW     = 3;
  localparam int FracBits  = 8;
  localparam int ExtraBits = 8;

  // Display mode codes.
  localparam logic [ModeW-1:0] ModeReal  = 3'd0;
  localparam logic [ModeW-1:0] ModeImag  = 3'd1;
  localparam logic [ModeW-1:0] ModeMag   = 3'd2;
  localparam logic [ModeW-1:0] ModePhase = 3'd3;
  localparam logic [ModeW-1:0] ModeReset = ModeImag;

  // Pipeline depths of the units.
  localparam int SqrtBits = 48;
  localparam int SqrtLat  = SqrtBits + 2;
  localparam int LogIters = 24;
  localparam int LogLat   = LogIters + 3;
  localparam int DivBits  = 31;
  localparam int AtanLat  = DivBits + 12;
  localparam int DlyLat   = SqrtLat + LogLat - AtanLat;
  localparam int FrontLen = 1 + SqrtLat + LogLat;

  // ln(2) in Q32 and 3/pi in Q30.
  localparam logic [31:0] LnTwo     = 32'd2977044472;
  localparam logic [29:0] ThreeByPi = 30'd1025347913;

  // Odd polynomial for atan on the first octant, Q30.
  localparam logic signed [31:0] CoefA9 = 32'sd22371518;
  localparam logic signed [31:0] PolyCoef [0:3] = '{
    -32'sd91410863, 32'sd193424926, -32'sd354656388, 32'sd1073597943
  };

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             nr;
    logic             ni;
    logic [InW-1:0]   mr;
    logic [InW-1:0]   mi;
  } cpm_side_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             nr;
    logic             ni;
  } cpm_sign_t;

  typedef struct packed {
    logic swapped;
    logic nr;
    logic ni;
    logic zero;
  } cpm_hue_t;

  // Signed division by 2^30 that truncates toward zero.
  function automatic logic signed [33:0] tdiv_q30(input logic signed [63:0] v);
    logic signed [63:0] adj;
    adj = v[63] ? (v + 64'sd1073741823) : v;
    return 34'(adj >>> 30);
  endfunction

endpackage

[hw/rtl/complex_to_color_pixel_map_top.sv]
// Top level of the complex sample to RGB pixel mapper.
// Throughput: one transaction per cycle unless the output stalls; the depth is set by
// the 48-stage square root followed by the 24 squaring stages of the logarithm unit.
// The whole pipeline advances together and freezes while a pixel waits on the output.
// Reset clears all valid bits and sets the display mode to imaginary; no clearing pass.
module complex_to_color_pixel_map_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [39:0] real_part,
  input  logic [39:0] imag_part,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  localparam int VLen = cpm_pkg::FrontLen;
  localparam int DLen = cpm_pkg::DlyLat;

  logic en;
  logic [2:0] display_mode;

  // Input stage: sign and magnitude of both parts, with the mode of this transaction.
  logic [39:0] mr0, mi0;
  logic        nr0, ni0;
  logic [2:0]  mode0;
  logic        vp [0:VLen-1];

  cpm_pkg::cpm_side_t side0, sq_side;
  logic [47:0]        root;

  logic [39:0]        sel;
  logic [47:0]        lx;
  logic               big;
  cpm_pkg::cpm_sign_t lg_in, lg_out;
  logic [29:0]        ln;

  logic [7:0] hr, hg, hb;
  logic [23:0] dl [0:DLen-1];

  logic [34:0] t20, t10;
  logic [11:0] pri;
  logic [10:0] pm_w;
  logic [7:0]  p_ri, p_m;
  logic [7:0]  r_c, g_c, b_c;

  // The pipeline moves whenever the output register is empty or being drained.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= cpm_pkg::ModeReset;
    end else if (cfg_valid) begin
      display_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr0   <= real_part[39];
      ni0   <= imag_part[39];
      mr0   <= real_part[39] ? (~real_part + 40'd1) : real_part;
      mi0   <= imag_part[39] ? (~imag_part + 40'd1) : imag_part;
      mode0 <= display_mode;
    end
  end

  // Valid bits run alongside the data through every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VLen; i++) vp[i] <= 1'b0;
    end else if (en) begin
      vp[0] <= in_valid;
      for (int i = 1; i < VLen; i++) vp[i] <= vp[i-1];
    end
  end

  assign side0.mode = mode0;
  assign side0.nr   = nr0;
  assign side0.ni   = ni0;
  assign side0.mr   = mr0;
  assign side0.mi   = mi0;

  cpm_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .a        (mr0),
    .b        (mi0),
    .side_in  (side0),
    .root     (root),
    .side_out (sq_side)
  );

  // The logarithm unit is shared: the magnitude in magnitude mode, otherwise the
  // selected part, each offset by one in its own fixed-point scale.
  assign sel = (sq_side.mode == cpm_pkg::ModeReal) ? sq_side.mr : sq_side.mi;
  assign big = (sq_side.mode == cpm_pkg::ModeMag);
  assign lx  = big ? (root + (48'(1) << (cpm_pkg::FracBits + cpm_pkg::ExtraBits)))
                   : (48'(sel) + (48'(1) << cpm_pkg::FracBits));
  assign lg_in.mode = sq_side.mode;
  assign lg_in.nr   = sq_side.nr;
  assign lg_in.ni   = sq_side.ni;

  cpm_log u_log (
    .clk      (clk),
    .en       (en),
    .x        (lx),
    .big      (big),
    .side_in  (lg_in),
    .ln       (ln),
    .side_out (lg_out)
  );

  // Hue path runs in parallel and is delayed to line up with the logarithm result.
  cpm_atan u_atan (
    .clk   (clk),
    .en    (en),
    .mr    (mr0),
    .mi    (mi0),
    .nr    (nr0),
    .ni    (ni0),
    .red   (hr),
    .green (hg),
    .blue  (hb)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= {hr, hg, hb};
      for (int i = 1; i < DLen; i++) dl[i] <= dl[i-1];
    end
  end

  // Intensity scaling with saturation at full scale.
  always_comb begin
    t20  = 35'(ln) * 35'd20;
    t10  = 35'(ln) * 35'd10;
    pri  = 12'd128 + 12'(t20[34:24]);
    pm_w = t10[34:24];
    p_ri = (pri > 12'd255) ? 8'd255 : pri[7:0];
    p_m  = (pm_w > 11'd255) ? 8'd255 : pm_w[7:0];
  end

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    unique case (lg_out.mode)
      cpm_pkg::ModeReal: begin
        r_c = lg_out.nr ? 8'd0 : p_ri;
        g_c = lg_out.nr ? p_ri : 8'd0;
      end
      cpm_pkg::ModeImag: begin
        r_c = lg_out.ni ? 8'd0 : p_ri;
        g_c = p_ri;
        b_c = lg_out.ni ? p_ri : 8'd0;
      end
      cpm_pkg::ModeMag: begin
        r_c = p_m;
        g_c = p_m;
        b_c = p_m;
      end
      cpm_pkg::ModePhase: begin
        r_c = dl[DLen-1][23:16];
        g_c = dl[DLen-1][15:8];
        b_c = dl[DLen-1][7:0];
      end
      default: begin
        r_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vp[VLen-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= r_c;
      green <= g_c;
      blue  <= b_c;
    end
  end

`ifndef SYNTH
  // A stalled output freezes the transaction waiting behind it.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vp[VLen-1]) && $stable(lg_out))
    else $error("pipeline tail moved during an output stall");

  // A new pixel only appears when the last stage held a valid transaction.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(vp[VLen-1]))
    else $error("output valid without a transaction in the last stage");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid directly after reset");
`endif

endmodule

[hw/rtl/cpm_sqrt.sv]
// Pipelined squared-magnitude and integer square root, one root bit per stage.
module cpm_sqrt (
  input  logic                  clk,
  input  logic                  en,
  input  logic [39:0]           a,
  input  logic [39:0]           b,
  input  cpm_pkg::cpm_side_t    side_in,
  output logic [47:0]           root,
  output cpm_pkg::cpm_side_t    side_out
);

  localparam int NB = cpm_pkg::SqrtBits;

  logic [39:0] pa2, pa1, pa0, pb2, pb1, pb0;
  cpm_pkg::cpm_side_t side_a;
  logic [80:0] vsum;

  logic [95:0]        rem [0:NB];
  logic [NB-1:0]      q   [0:NB];
  cpm_pkg::cpm_side_t sd  [0:NB];

  // Split 40-bit operands into 20-bit halves so every product stays narrow.
  always_ff @(posedge clk) begin
    if (en) begin
      pa2    <= a[39:20] * a[39:20];
      pa1    <= a[39:20] * a[19:0];
      pa0    <= a[19:0]  * a[19:0];
      pb2    <= b[39:20] * b[39:20];
      pb1    <= b[39:20] * b[19:0];
      pb0    <= b[19:0]  * b[19:0];
      side_a <= side_in;
    end
  end

  assign vsum = ((81'(pa2) + 81'(pb2)) << 40) + ((81'(pa1) + 81'(pb1)) << 21)
              + 81'(pa0) + 81'(pb0);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {vsum[79:0], 16'b0};
      q[0]   <= '0;
      sd[0]  <= side_a;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int I = NB - 1 - k;
    logic [95:0] trial;
    assign trial = (96'(q[k]) << (I + 1)) | (96'(1) << (2 * I));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          q[k+1]   <= q[k] | (NB'(1) << I);
        end else begin
          rem[k+1] <= rem[k];
          q[k+1]   <= q[k];
        end
        sd[k+1] <= sd[k];
      end
    end
  end

  assign root     = q[NB];
  assign side_out = sd[NB];

endmodule

[hw/rtl/cpm_log.sv]
// Pipelined natural logarithm in Q24 by normalization and repeated squaring.
module cpm_log (
  input  logic               clk,
  input  logic               en,
  input  logic [47:0]        x,
  input  logic               big,
  input  cpm_pkg::cpm_sign_t side_in,
  output logic [29:0]        ln,
  output cpm_pkg::cpm_sign_t side_out
);

  localparam int NI = cpm_pkg::LogIters;

  logic [2:0]  k_c, k1, f_c;
  logic        found_k, found_f;
  logic [47:0] xs1, norm;
  logic        big1;
  cpm_pkg::cpm_sign_t s1;
  logic [5:0]  e_c;

  logic [30:0]        m  [0:NI];
  logic [NI-1:0]      fr [0:NI];
  logic [5:0]         e  [0:NI];
  cpm_pkg::cpm_sign_t sd [0:NI];

  logic [61:0]        prod;
  cpm_pkg::cpm_sign_t s_out;

  // Coarse step: count leading zero bytes.
  always_comb begin
    k_c     = '0;
    found_k = 1'b0;
    for (int j = 0; j < 6; j++) begin
      if (!found_k && (x[47-8*j -: 8] != 8'd0)) begin
        k_c     = 3'(j);
        found_k = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs1  <= x << {k_c, 3'b000};
      k1   <= k_c;
      big1 <= big;
      s1   <= side_in;
    end
  end

  // Fine step: leading zeros within the top byte.
  always_comb begin
    f_c     = '0;
    found_f = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!found_f && xs1[47-j]) begin
        f_c     = 3'(j);
        found_f = 1'b1;
      end
    end
    norm = xs1 << f_c;
    e_c  = 6'd47 - {k1, 3'b000} - 6'(f_c)
         - (big1 ? 6'(cpm_pkg::FracBits + cpm_pkg::ExtraBits) : 6'(cpm_pkg::FracBits));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0]  <= norm[47:17];
      fr[0] <= '0;
      e[0]  <= e_c;
      sd[0] <= s1;
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] mm;
    assign sq = 62'(m[i]) * 62'(m[i]);
    assign mm = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m[i+1]  <= mm[31] ? mm[31:1] : mm[30:0];
        fr[i+1] <= {fr[i][NI-2:0], mm[31]};
        e[i+1]  <= e[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= 62'({e[NI], fr[NI]}) * 62'(cpm_pkg::LnTwo);
      s_out <= sd[NI];
    end
  end

  assign ln       = prod[61:32];
  assign side_out = s_out;

endmodule

[hw/rtl/cpm_atan.sv]
// Pipelined phase to hue color: octant fold, divider, atan polynomial and sector select.
module cpm_atan (
  input  logic        clk,
  input  logic        en,
  input  logic [39:0] mr,
  input  logic [39:0] mi,
  input  logic        nr,
  input  logic        ni,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  localparam int ND = cpm_pkg::DivBits;
  localparam logic signed [34:0] Q3  = 35'sd3221225472;
  localparam logic signed [34:0] Q3H = 35'sd1610612736;
  localparam logic signed [34:0] Q6  = 35'sd6442450944;
  localparam logic [30:0]        QOne = 31'd1073741824;

  logic [39:0] x1, y1;
  cpm_pkg::cpm_hue_t fl1;
  logic [3:0]  s_c;

  logic [61:0]       rem [0:ND];
  logic [31:0]       xd  [0:ND];
  logic [ND-1:0]     qd  [0:ND];
  cpm_pkg::cpm_hue_t fd  [0:ND];

  logic [61:0] zz;
  logic [30:0] w0, z0;
  cpm_pkg::cpm_hue_t fl0;

  logic signed [63:0] prod [0:4];
  logic [30:0]        wq   [0:4];
  logic [30:0]        zq   [0:4];
  cpm_pkg::cpm_hue_t  fp   [0:4];

  logic signed [33:0] a_c;
  logic [30:0]        a_cl;
  logic [60:0]        prod6;
  cpm_pkg::cpm_hue_t  fl6;

  logic signed [34:0] u_c, u1_c, u2_c, u2;
  cpm_pkg::cpm_hue_t  fl7;
  logic signed [34:0] u3_c, u4_c;
  logic [32:0]        t_c, t;

  logic [2:0]  sector;
  logic [29:0] f;
  logic [37:0] up_p;
  logic [30:0] df;
  logic [38:0] dn_p;
  logic [7:0]  up, down;

  // Fold to the first octant.
  always_ff @(posedge clk) begin
    if (en) begin
      if (mi > mr) begin
        x1 <= mi;
        y1 <= mr;
      end else begin
        x1 <= mr;
        y1 <= mi;
      end
      fl1.swapped <= (mi > mr);
      fl1.nr      <= nr;
      fl1.ni      <= ni;
      fl1.zero    <= (mr == '0) && (mi == '0);
    end
  end

  // Bring the larger part below 2^32.
  always_comb begin
    s_c = '0;
    for (int j = 0; j < 8; j++) begin
      if (x1[32+j]) s_c = 4'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xd[0]  <= 32'(x1 >> s_c);
      rem[0] <= {32'(y1 >> s_c), 30'b0};
      qd[0]  <= '0;
      fd[0]  <= fl1;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int I = ND - 1 - k;
    logic [61:0] dv;
    assign dv = 62'(xd[k]) << I;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= dv) begin
          rem[k+1] <= rem[k] - dv;
          qd[k+1]  <= qd[k] | (ND'(1) << I);
        end else begin
          rem[k+1] <= rem[k];
          qd[k+1]  <= qd[k];
        end
        xd[k+1] <= xd[k];
        fd[k+1] <= fd[k];
      end
    end
  end

  assign zz = 62'(qd[ND]) * 62'(qd[ND]);

  always_ff @(posedge clk) begin
    if (en) begin
      w0  <= zz[60:30];
      z0  <= qd[ND];
      fl0 <= fd[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= cpm_pkg::CoefA9 * $signed({1'b0, w0});
      wq[0]   <= w0;
      zq[0]   <= z0;
      fp[0]   <= fl0;
    end
  end

  // Horner steps; the last one multiplies by z instead of w.
  for (genvar j = 0; j < 4; j++) begin : g_poly
    logic signed [31:0] p;
    logic [30:0]        opnd;
    assign p    = cpm_pkg::PolyCoef[j] + 32'(cpm_pkg::tdiv_q30(prod[j]));
    assign opnd = (j == 3) ? zq[j] : wq[j];
    always_ff @(posedge clk) begin
      if (en) begin
        prod[j+1] <= p * $signed({1'b0, opnd});
        wq[j+1]   <= wq[j];
        zq[j+1]   <= zq[j];
        fp[j+1]   <= fp[j];
      end
    end
  end

  assign a_c  = cpm_pkg::tdiv_q30(prod[4]);
  assign a_cl = a_c[33] ? 31'd0 : a_c[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod6 <= 61'(a_cl) * 61'(cpm_pkg::ThreeByPi);
      fl6   <= fp[4];
    end
  end

  always_comb begin
    u_c  = $signed({4'b0, prod6[60:30]});
    u1_c = fl6.swapped ? (Q3H - u_c) : u_c;
    u2_c = fl6.nr ? (Q3 - u1_c) : u1_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2  <= u2_c;
      fl7 <= fl6;
    end
  end

  always_comb begin
    u3_c = fl7.ni ? -u2 : u2;
    u4_c = u3_c + Q3;
    priority if (fl7.zero) t_c = 33'(Q3);
    else if (u4_c < 0)    t_c = '0;
    else if (u4_c > Q6)   t_c = 33'(Q6);
    else                  t_c = u4_c[32:0];
  end

  always_ff @(posedge clk) begin
    if (en) t <= t_c;
  end

  always_comb begin
    sector = t[32:30];
    f      = t[29:0];
    up_p   = 38'(f) * 38'd255;
    df     = QOne - 31'(f);
    dn_p   = 39'(df) * 39'd255;
    up     = up_p[37:30];
    down   = dn_p[37:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (sector)
        3'd0, 3'd6: begin red <= 8'd255; green <= up;     blue <= 8'd0;   end
        3'd1:       begin red <= down;   green <= 8'd255; blue <= 8'd0;   end
        3'd2:       begin red <= 8'd0;   green <= 8'd255; blue <= up;     end
        3'd3:       begin red <= 8'd0;   green <= down;   blue <= 8'd255; end
        3'd4:       begin red <= up;     green <= 8'd0;   blue <= 8'd255; end
        default:    begin red <= 8'd255; green <= 8'd0;   blue <= down;   end
      endcase
    end
  end

endmodule
